// ===== src/mlt_pkg.sv =====
// Shared types and constants for the MAC learning table.
`default_nettype none

package mlt_pkg;

   // Command codes of a request.
   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_LEARN  = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   localparam logic [7:0] AGE_MAX         = 8'd255;
   localparam logic [7:0] AGE_LIMIT_RESET = 8'd30;

   // Configuration port: one 32-bit register per word.
   localparam int         CSR_ADDR_W        = 3;
   localparam int         CSR_DATA_W        = 32;
   localparam logic [0:0] CSR_AGE_LIMIT_IDX = 1'b0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [47:0] mac_addr;
      logic [3:0]  port_in;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] port_out;
      logic [6:0] removed_count;
      logic       table_full;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [47:0] mac_addr;
      logic [3:0]  port;
      logic [7:0]  age;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic scan_start;
      logic scan_rd;
      logic finish;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_last;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== src/mlt_ctrl.sv =====
// Controller state machine that sequences clearing, table scans and result hand-off.
`default_nettype none

module mlt_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output mlt_pkg::ctl_type    ctl,
   input  mlt_pkg::sts_type    sts
);
   import mlt_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.clear_wr = 1'b1;
            if (sts.idx_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.scan_rd = 1'b1;
            if (sts.idx_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last entry read is being examined in this cycle.
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && sts.idx_last) |=> (state_ff == S_DRAIN))
      else $error("scan did not end after the last entry");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> sts.rsp_free)
      else $error("result loaded while the output register was occupied");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.clear_wr, ctl.scan_start, ctl.scan_rd, ctl.finish}))
      else $error("more than one datapath command at once");

endmodule

`default_nettype wire

// ===== src/mlt_dpath.sv =====
// Datapath: entry memory, scan pipeline, match and free-slot tracking, result register.
`default_nettype none

module mlt_dpath #(
   parameter int ENTRIES = 64
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  mlt_pkg::ctl_type    ctl,
   output mlt_pkg::sts_type    sts,
   input  mlt_pkg::req_type    req_payload,
   input  wire logic [7:0]     age_limit,
   input  wire logic           rsp_ready,
   output logic                rsp_valid,
   output mlt_pkg::rsp_type    rsp_payload
);
   import mlt_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   entry_type mem [ENTRIES];

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   entry_type        rd_data_ff;
   req_type          req_ff;

   logic             found_ff;
   logic [IDX_W-1:0] found_idx_ff;
   logic [3:0]       found_port_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             is_tick;
   logic             is_learn;
   logic             hit_now;
   logic             free_now;
   logic [7:0]       age_inc;
   logic             age_out;
   logic             wb_wr;
   logic             learn_wr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [CNT_W+6:0] cnt_ext;

   assign is_tick  = (req_ff.cmd == CMD_TICK);
   assign is_learn = (req_ff.cmd == CMD_LEARN);

   assign hit_now  = rd_vld_ff && rd_data_ff.valid &&
                     (rd_data_ff.mac_addr == req_ff.mac_addr);
   assign free_now = rd_vld_ff && !rd_data_ff.valid;

   assign age_inc  = (rd_data_ff.age == AGE_MAX) ? AGE_MAX : rd_data_ff.age + 8'd1;
   assign age_out  = (age_inc > age_limit);
   assign wb_wr    = rd_vld_ff && is_tick && rd_data_ff.valid;
   assign learn_wr = ctl.finish && is_learn && (found_ff || free_found_ff);

   always_comb begin
      wr_en   = ctl.clear_wr || wb_wr || learn_wr;
      wr_addr = idx_ff;
      wr_data = '0;
      if (ctl.clear_wr) begin
         wr_addr = idx_ff;
         wr_data = '0;
      end else if (wb_wr) begin
         wr_addr          = rd_idx_ff;
         wr_data.valid    = !age_out;
         wr_data.mac_addr = rd_data_ff.mac_addr;
         wr_data.port     = rd_data_ff.port;
         wr_data.age      = age_inc;
      end else begin
         // A refresh and a new entry store the same word; only the slot differs.
         wr_addr          = found_ff ? found_idx_ff : free_idx_ff;
         wr_data.valid    = 1'b1;
         wr_data.mac_addr = req_ff.mac_addr;
         wr_data.port     = req_ff.port_in;
         wr_data.age      = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.scan_rd) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.scan_start) begin
         idx_in = '0;
      end else if (ctl.clear_wr || ctl.scan_rd) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end
   end

   assign cnt_ext = {7'd0, cnt_ff};

   always_comb begin
      rsp_in               = '0;
      rsp_in.hit           = found_ff &&
                             (req_ff.cmd == CMD_LOOKUP || req_ff.cmd == CMD_LEARN);
      rsp_in.port_out      = rsp_in.hit ? found_port_ff : 4'd0;
      rsp_in.removed_count = is_tick ? cnt_ext[6:0] : 7'd0;
      rsp_in.table_full    = is_learn && !found_ff && !free_found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         rd_vld_ff <= ctl.scan_rd;
         if (ctl.scan_start) begin
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
            cnt_ff        <= '0;
         end else begin
            if (hit_now) begin
               found_ff <= 1'b1;
            end
            if (free_now) begin
               free_found_ff <= 1'b1;
            end
            if (wb_wr && age_out) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (ctl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (ctl.scan_start) begin
         req_ff <= req_payload;
      end
      // Only the lowest-numbered match and free slot are kept.
      if (hit_now && !found_ff) begin
         found_idx_ff  <= rd_idx_ff;
         found_port_ff <= rd_data_ff.port;
      end
      if (free_now && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.idx_last = (idx_ff == LAST_IDX);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   a_no_wr_clash: assert property (@(posedge clock) disable iff (reset)
      !(wb_wr && learn_wr) && !(ctl.clear_wr && (wb_wr || learn_wr)))
      else $error("two memory writes requested in one cycle");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (found_ff && !ctl.scan_start) |=> found_ff)
      else $error("match flag dropped during a scan");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result changed while waiting to be accepted");

endmodule

`default_nettype wire

// ===== src/mac_learning_table_with_aging.sv =====
// Top level of the MAC learning table: configuration register and module wiring.
//
// Address table of ENTRIES slots mapping 48-bit MAC addresses to 4-bit ports. Each request
// (lookup, learn or one-second tick) scans every slot in order through one read port of the
// entry memory, one slot per cycle; a drain state then examines the last slot, and a finish
// state writes a learned entry and loads the result register. The block then returns to
// idle, so it takes no new request before it is through with the last one; the load waits
// for as long as an earlier result is still held in the output register. After reset the
// block first clears the valid bit of every slot, one per cycle, and accepts no request
// until every slot is cleared. The age_limit register should only be written while no
// request is in flight. A learn refreshes a known address or takes the lowest free slot,
// and is dropped with table_full set when no slot is free.
`default_nettype none

module mac_learning_table_with_aging #(
   parameter int ENTRIES = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  mlt_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output mlt_pkg::rsp_type                      rsp_payload,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mlt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mlt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mlt_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import mlt_pkg::*;

   logic [7:0] age_limit_ff;
   logic [7:0] age_limit_in;
   logic       sel_age_limit;
   ctl_type    ctl;
   sts_type    sts;

   assign csr_pready    = 1'b1;
   assign sel_age_limit = (csr_paddr[2:2] == CSR_AGE_LIMIT_IDX);

   always_comb begin
      age_limit_in = age_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_age_limit) begin
         age_limit_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RESET;
      end else begin
         age_limit_ff <= age_limit_in;
      end
   end

   assign csr_prdata = sel_age_limit ? {24'd0, age_limit_ff} : '0;

   mlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   mlt_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .req_payload (req_payload),
      .age_limit   (age_limit_ff),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
